// ----- src/swfs_pkg.sv -----
package swfs_pkg;

    // default configuration
    localparam int FFT_POINTS  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int TW_BITS     = 16;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_XFORM = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_BF_RDA,
        ST_BF_RDB,
        ST_BF_MUL,
        ST_BF_SUM,
        ST_BF_WRA,
        ST_BF_WRB,
        ST_RD_WAIT
    } t_state;

    // spectrum store write data source
    typedef enum logic [1:0] {
        WS_ZERO,
        WS_SAMPLE,
        WS_SUM,
        WS_DIFF
    } t_wsel;

    typedef struct packed {
        logic  win_we;
        logic  win_clr;
        logic  win_re;
        logic  spec_we;
        t_wsel spec_wsel;
        logic  spec_re;
        logic  ld_a;
        logic  mul_en;
        logic  sum_en;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ----- src/swfs_twiddle_rom.sv -----
module swfs_twiddle_rom #(
    parameter int N_POINTS = swfs_pkg::FFT_POINTS
) (
    input  logic                              i_clk,
    input  logic [$clog2(N_POINTS)-2:0]       i_addr,
    output logic [2*swfs_pkg::TW_BITS-1:0]    o_data
);
    import swfs_pkg::*;

    localparam int HALF = N_POINTS / 2;
    localparam int QTR  = N_POINTS / 4;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;

    typedef logic [2*TW_BITS-1:0] t_rom [HALF];

    // (a * b) >> 62 kept to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // restoring division, quotient and remainder
    function automatic logic [127:0] udivmod(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return {r[63:0], q};
    endfunction

    function automatic logic [15:0] q62_to_q15(input logic [63:0] v);
        logic [63:0] q;
        if (v[63])
            return 16'd0;
        q = (v + (64'd1 << 46)) >> 47;
        return (q > 64'd32767) ? 16'd32767 : q[15:0];
    endfunction

    // cos and sin of (pi/2) * m / d, returned as {sin, cos}
    function automatic logic [31:0] quarter_sincos(input logic [63:0] m, input logic [63:0] d);
        logic [127:0] qr;
        logic [63:0]  f, r, x, x2, ts, tc, ss, cs, n;
        qr = udivmod(m, d);
        f  = qr[63:0];
        r  = qr[127:64];
        for (int i = 0; i < 62; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= d) begin
                r    = r - d;
                f[0] = 1'b1;
            end
        end
        x  = mul_q62(HALF_PI_Q62, f);
        x2 = mul_q62(x, x);
        ts = x;
        ss = x;
        tc = Q62_ONE;
        cs = Q62_ONE;
        for (int i = 1; i <= 14; i++) begin
            n  = 64'(2 * i);
            qr = udivmod(mul_q62(ts, x2), n * (n + 64'd1));
            ts = qr[63:0];
            qr = udivmod(mul_q62(tc, x2), (n - 64'd1) * n);
            tc = qr[63:0];
            if (i % 2 == 1) begin
                ss = ss - ts;
                cs = cs - tc;
            end else begin
                ss = ss + ts;
                cs = cs + tc;
            end
        end
        return {q62_to_q15(ss), q62_to_q15(cs)};
    endfunction

    // entry holds {sin, cos} of 2 pi k / N
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [31:0] sc;
        for (int k = 0; k < HALF; k++) begin
            if (k <= QTR) begin
                sc     = quarter_sincos(64'(k), 64'(QTR));
                rom[k] = sc;
            end else begin
                sc     = quarter_sincos(64'(HALF - k), 64'(QTR));
                rom[k] = {sc[31:16], 16'(-sc[15:0])};
            end
        end
        return rom;
    endfunction

    localparam t_rom TW_ROM = build_rom();

    logic [2*TW_BITS-1:0] r_data;

    // registered read
    always_ff @(posedge i_clk) begin
        r_data <= TW_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

// ----- src/swfs_datapath.sv -----
module swfs_datapath #(
    parameter int N_POINTS    = swfs_pkg::FFT_POINTS,
    parameter int SAMPLE_BITS = swfs_pkg::SAMPLE_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  swfs_pkg::t_cmd                               i_cmd,
    output swfs_pkg::t_stat                              o_stat,
    input  logic [SAMPLE_BITS-1:0]                       i_left,
    input  logic [SAMPLE_BITS-1:0]                       i_right,
    input  logic [$clog2(N_POINTS)-1:0]                  i_win_waddr,
    input  logic [$clog2(N_POINTS)-1:0]                  i_win_raddr,
    input  logic [$clog2(N_POINTS)-1:0]                  i_spec_waddr,
    input  logic [$clog2(N_POINTS)-1:0]                  i_spec_raddr,
    input  logic [2*swfs_pkg::TW_BITS-1:0]               i_tw,
    input  logic                                         i_out_ready,
    output logic                                         o_out_valid,
    output logic [SAMPLE_BITS+$clog2(N_POINTS)-1:0]      o_bin_real,
    output logic [SAMPLE_BITS+$clog2(N_POINTS)-1:0]      o_bin_imag
);
    import swfs_pkg::*;

    localparam int LOG2N = $clog2(N_POINTS);
    localparam int BW    = SAMPLE_BITS + LOG2N;
    localparam int PW    = BW + TW_BITS;

    logic [SAMPLE_BITS-1:0] win_mem [N_POINTS];
    logic [2*BW-1:0]        spec_mem [N_POINTS];

    logic [SAMPLE_BITS-1:0] r_win_q;
    logic [2*BW-1:0]        r_spec_q;
    logic [BW-1:0]          r_ar, r_ai, r_vr, r_vi;
    logic signed [PW-1:0]   r_p1, r_p2, r_p3, r_p4;
    logic [BW-1:0]          r_out_re, r_out_im;
    logic                   r_out_valid;

    logic signed [SAMPLE_BITS:0] mix_sum;
    logic [SAMPLE_BITS-1:0]      mix;
    logic [SAMPLE_BITS-1:0]      win_wdata;
    logic [2*BW-1:0]             spec_wdata;
    logic signed [BW-1:0]        br, bi;
    logic signed [TW_BITS-1:0]   wr, wi;
    logic signed [PW-1:0]        p1, p2, p3, p4;
    logic signed [PW:0]          sr, si;
    logic [PW:0]                 rr, ri;

    // downmix: floor((left + right) / 2)
    assign mix_sum   = $signed({i_left[SAMPLE_BITS-1], i_left})
                     + $signed({i_right[SAMPLE_BITS-1], i_right});
    assign mix       = mix_sum[SAMPLE_BITS:1];
    assign win_wdata = i_cmd.win_clr ? '0 : mix;

    // sample window memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.win_we)
            win_mem[i_win_waddr] <= win_wdata;
        if (i_cmd.win_re)
            r_win_q <= win_mem[i_win_raddr];
    end

    // spectrum store write data
    always_comb begin
        case (i_cmd.spec_wsel)
            WS_ZERO:   spec_wdata = '0;
            WS_SAMPLE: spec_wdata = {{BW{1'b0}},
                                     {{LOG2N{r_win_q[SAMPLE_BITS-1]}}, r_win_q}};
            WS_SUM:    spec_wdata = {r_ai + r_vi, r_ar + r_vr};
            WS_DIFF:   spec_wdata = {r_ai - r_vi, r_ar - r_vr};
            default:   spec_wdata = '0;
        endcase
    end

    // spectrum store, also the transform workspace
    always_ff @(posedge i_clk) begin
        if (i_cmd.spec_we)
            spec_mem[i_spec_waddr] <= spec_wdata;
        if (i_cmd.spec_re)
            r_spec_q <= spec_mem[i_spec_raddr];
    end

    // butterfly: complex twiddle product, then round to nearest
    assign br = $signed(r_spec_q[BW-1:0]);
    assign bi = $signed(r_spec_q[2*BW-1:BW]);
    assign wr = $signed(i_tw[TW_BITS-1:0]);
    assign wi = $signed(i_tw[2*TW_BITS-1:TW_BITS]);
    assign p1 = wr * br;
    assign p2 = wi * bi;
    assign p3 = wr * bi;
    assign p4 = wi * br;
    assign sr = (PW+1)'(r_p1) - (PW+1)'(r_p2) + (PW+1)'(16384);
    assign si = (PW+1)'(r_p3) + (PW+1)'(r_p4) + (PW+1)'(16384);
    assign rr = sr >>> 15;
    assign ri = si >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_a) begin
            r_ar <= r_spec_q[BW-1:0];
            r_ai <= r_spec_q[2*BW-1:BW];
        end
        if (i_cmd.mul_en) begin
            r_p1 <= p1;
            r_p2 <= p2;
            r_p3 <= p3;
            r_p4 <= p4;
        end
        if (i_cmd.sum_en) begin
            r_vr <= rr[BW-1:0];
            r_vi <= ri[BW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_re <= r_spec_q[BW-1:0];
            r_out_im <= r_spec_q[2*BW-1:BW];
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_bin_real      = r_out_re;
    assign o_bin_imag      = r_out_im;

endmodule

// ----- src/swfs_ctrl.sv -----
module swfs_ctrl #(
    parameter int N_POINTS = swfs_pkg::FFT_POINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_mode,
    input  logic [$clog2(N_POINTS)-1:0]       i_bin_index,
    input  swfs_pkg::t_stat                   i_stat,
    output swfs_pkg::t_cmd                    o_cmd,
    output logic [$clog2(N_POINTS)-1:0]       o_win_waddr,
    output logic [$clog2(N_POINTS)-1:0]       o_win_raddr,
    output logic [$clog2(N_POINTS)-1:0]       o_spec_waddr,
    output logic [$clog2(N_POINTS)-1:0]       o_spec_raddr,
    output logic [$clog2(N_POINTS)-2:0]       o_tw_addr
);
    import swfs_pkg::*;

    localparam int LOG2N = $clog2(N_POINTS);
    localparam int SW    = $clog2(LOG2N);
    localparam logic [SW-1:0]    LAST_STAGE = SW'(LOG2N - 1);
    localparam logic [SW-1:0]    TW_SHIFT   = SW'(LOG2N - 1);

    t_state             r_state, n_state;
    logic [LOG2N-1:0]   r_head, n_head;
    logic [LOG2N-1:0]   r_n, n_n;
    logic [SW-1:0]      r_stage, n_stage;
    logic [LOG2N-2:0]   r_j, n_j;

    logic [LOG2N-1:0]   j_ext, lo_mask, addr_a, addr_b, rev_n;

    function automatic logic [LOG2N-1:0] bit_rev(input logic [LOG2N-1:0] v);
        logic [LOG2N-1:0] r;
        for (int b = 0; b < LOG2N; b++)
            r[b] = v[LOG2N-1-b];
        return r;
    endfunction

    // butterfly addresses for this stage
    assign j_ext   = {1'b0, r_j};
    assign lo_mask = ~({LOG2N{1'b1}} << r_stage);
    assign addr_a  = (((j_ext >> r_stage) << r_stage) << 1) | (j_ext & lo_mask);
    assign addr_b  = addr_a | (LOG2N'(1) << r_stage);
    assign rev_n   = bit_rev(r_n);

    assign o_tw_addr   = (r_j & lo_mask[LOG2N-2:0]) << (TW_SHIFT - r_stage);
    assign o_win_waddr = (r_state == ST_CLEAR) ? r_n : r_head;
    assign o_win_raddr = r_head + r_n;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_head  <= '0;
            r_n     <= '0;
            r_stage <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_n     <= n_n;
            r_stage <= n_stage;
            r_j     <= n_j;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_n          = r_n;
        n_stage      = r_stage;
        n_j          = r_j;
        o_cmd        = '0;
        o_ready      = 1'b0;
        o_spec_waddr = r_n;
        o_spec_raddr = addr_a;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.win_we    = 1'b1;
                o_cmd.win_clr   = 1'b1;
                o_cmd.spec_we   = 1'b1;
                o_cmd.spec_wsel = WS_ZERO;
                n_n             = r_n + 1'b1;
                if (&r_n)
                    n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_spec_raddr = i_bin_index;
                if (i_valid) begin
                    unique case (t_mode'(i_mode))
                        MODE_PUSH: begin
                            o_cmd.win_we = 1'b1;
                            n_head       = r_head + 1'b1;
                        end
                        MODE_XFORM: begin
                            o_cmd.win_we = 1'b1;
                            n_head       = r_head + 1'b1;
                            n_n          = '0;
                            n_state      = ST_LOAD_RD;
                        end
                        MODE_READ: begin
                            o_cmd.spec_re = 1'b1;
                            n_state       = ST_RD_WAIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // copy the window, oldest first, into bit-reversed order
            ST_LOAD_RD: begin
                o_cmd.win_re = 1'b1;
                n_state      = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                o_cmd.spec_we   = 1'b1;
                o_cmd.spec_wsel = WS_SAMPLE;
                o_spec_waddr    = rev_n;
                n_n             = r_n + 1'b1;
                if (&r_n) begin
                    n_stage = '0;
                    n_j     = '0;
                    n_state = ST_BF_RDA;
                end else begin
                    n_state = ST_LOAD_RD;
                end
            end
            ST_BF_RDA: begin
                o_cmd.spec_re = 1'b1;
                o_spec_raddr  = addr_a;
                n_state       = ST_BF_RDB;
            end
            ST_BF_RDB: begin
                o_cmd.spec_re = 1'b1;
                o_cmd.ld_a    = 1'b1;
                o_spec_raddr  = addr_b;
                n_state       = ST_BF_MUL;
            end
            ST_BF_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_BF_SUM;
            end
            ST_BF_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = ST_BF_WRA;
            end
            ST_BF_WRA: begin
                o_cmd.spec_we   = 1'b1;
                o_cmd.spec_wsel = WS_SUM;
                o_spec_waddr    = addr_a;
                n_state         = ST_BF_WRB;
            end
            ST_BF_WRB: begin
                o_cmd.spec_we   = 1'b1;
                o_cmd.spec_wsel = WS_DIFF;
                o_spec_waddr    = addr_b;
                n_j             = r_j + 1'b1;
                n_state         = ST_BF_RDA;
                if (&r_j) begin
                    if (r_stage == LAST_STAGE) begin
                        n_stage = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                    end
                end
            end
            ST_RD_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sliding_window_fft_spectrum.sv -----
// Push (mode 0) writes one sample into the window; a bin read (mode 2) reads
// the spectrum store, then loads the output register once it is free; that
// register holds the result until the sink takes it. Transform (mode 1) copies
// the window into the store in bit-reversed order, then runs the butterflies
// one at a time on the store's read and write ports. Reset: a clearing pass
// zeroes the window and the store; no transaction is accepted until it ends.
module sliding_window_fft_spectrum #(
    parameter int N_POINTS    = swfs_pkg::FFT_POINTS,
    parameter int SAMPLE_BITS = swfs_pkg::SAMPLE_BITS
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_s_axis_tvalid,
    output logic                                                   o_s_axis_tready,
    // left_sample, right_sample, bin_index, zero pad
    input  logic [((2*SAMPLE_BITS+$clog2(N_POINTS)+7)/8)*8-1:0]    i_s_axis_tdata,
    // mode
    input  logic [1:0]                                             i_s_axis_tuser,
    output logic                                                   o_m_axis_tvalid,
    input  logic                                                   i_m_axis_tready,
    // bin_real, bin_imag, zero pad
    output logic [((2*(SAMPLE_BITS+$clog2(N_POINTS))+7)/8)*8-1:0]  o_m_axis_tdata
);
    import swfs_pkg::*;

    localparam int LOG2N  = $clog2(N_POINTS);
    localparam int BW     = SAMPLE_BITS + LOG2N;
    localparam int OUT_DW = ((2*BW + 7) / 8) * 8;

    t_cmd                  cmd;
    t_stat                 stat;
    logic [LOG2N-1:0]      win_waddr, win_raddr, spec_waddr, spec_raddr;
    logic [LOG2N-2:0]      tw_addr;
    logic [2*TW_BITS-1:0]  tw;
    logic [BW-1:0]         bin_real, bin_imag;

    swfs_ctrl #(.N_POINTS(N_POINTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_mode       (i_s_axis_tuser),
        .i_bin_index  (i_s_axis_tdata[2*SAMPLE_BITS +: LOG2N]),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_win_waddr  (win_waddr),
        .o_win_raddr  (win_raddr),
        .o_spec_waddr (spec_waddr),
        .o_spec_raddr (spec_raddr),
        .o_tw_addr    (tw_addr)
    );

    swfs_twiddle_rom #(.N_POINTS(N_POINTS)) u_rom (
        .i_clk  (i_clk),
        .i_addr (tw_addr),
        .o_data (tw)
    );

    swfs_datapath #(.N_POINTS(N_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_left       (i_s_axis_tdata[0 +: SAMPLE_BITS]),
        .i_right      (i_s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS]),
        .i_win_waddr  (win_waddr),
        .i_win_raddr  (win_raddr),
        .i_spec_waddr (spec_waddr),
        .i_spec_raddr (spec_raddr),
        .i_tw         (tw),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_bin_real   (bin_real),
        .o_bin_imag   (bin_imag)
    );

    assign o_m_axis_tdata = OUT_DW'({bin_imag, bin_real});

endmodule
